// ----- hdl/pcbp_pkg.sv -----
// Package for the prefix code bit packer.
// Holds the item structs, request and status codes and the stage struct.
// No dependencies.
package pcbp_pkg;

  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_ENCODE = 2'd1;
  localparam logic [1:0] REQ_FINISH = 2'd2;

  localparam logic [1:0] ST_BYTE    = 2'd0;
  localparam logic [1:0] ST_UNKNOWN = 2'd1;
  localparam logic [1:0] ST_FLUSH   = 2'd2;

  localparam int CODE_W = 32;
  localparam int LEN_FW = 6;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [7:0]        symbol;
    logic [CODE_W-1:0] code_word;
    logic [LEN_FW-1:0] code_length;
  } req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       last;
  } res_t;

  typedef struct packed {
    logic valid;
    logic finish;
    logic known;
  } stage_t;

endpackage

// ----- hdl/pcbp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Read data holds while rd_en is low. No dependencies.
module pcbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hdl/pcbp_lookup.sv -----
// Code table lookup stage: code/length RAM, per-entry valid bits and the
// lookup stage register. Depends on pcbp_pkg and pcbp_ram.
module pcbp_lookup #(
  parameter int MAX_CODE_LEN = 32,
  parameter int SYMBOLS      = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  pcbp_pkg::req_t                req,
  input  logic                          go,
  output pcbp_pkg::stage_t              stage,
  output logic [pcbp_pkg::CODE_W-1:0]   code,
  output logic [pcbp_pkg::LEN_FW-1:0]   len
);
  import pcbp_pkg::*;

  localparam int LEN_CAP = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;
  localparam int LEN_W   = $clog2(LEN_CAP + 1);
  localparam int IDX_W   = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam int ENTRY_W = CODE_W + LEN_W;
  localparam logic [8:0] SYM_LIMIT = 9'(SYMBOLS);

  logic [SYMBOLS-1:0] vbits;
  logic               in_range;
  logic [IDX_W-1:0]   idx;
  logic [LEN_FW-1:0]  len_cap;
  logic [CODE_W-1:0]  mask;
  logic               wr_en;
  logic               rd_en;
  logic [ENTRY_W-1:0] wr_data;
  logic [ENTRY_W-1:0] rd_data;
  logic               st_valid;
  logic               st_finish;
  logic               st_known;

  assign in_range = {1'b0, req.symbol} < SYM_LIMIT;
  assign idx      = req.symbol[IDX_W-1:0];
  assign len_cap  = (req.code_length > LEN_FW'(LEN_CAP)) ? LEN_FW'(LEN_CAP) : req.code_length;
  assign mask     = CODE_W'((33'd1 << len_cap) - 33'd1);
  assign wr_data  = {req.code_word & mask, LEN_W'(len_cap)};
  assign wr_en    = accept && (req.req_type == REQ_LOAD) && in_range;
  assign rd_en    = accept && (req.req_type == REQ_ENCODE);

  pcbp_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(SYMBOLS)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(idx),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(idx),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vbits    <= '0;
      st_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        vbits[idx] <= (len_cap != '0);
      end
      if (accept) begin
        st_valid <= (req.req_type == REQ_ENCODE) || (req.req_type == REQ_FINISH);
      end else if (go) begin
        st_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st_finish <= (req.req_type == REQ_FINISH);
      st_known  <= in_range && vbits[idx];
    end
  end

  assign stage.valid  = st_valid;
  assign stage.finish = st_finish;
  assign stage.known  = st_known;
  assign code = rd_data[ENTRY_W-1:LEN_W];
  assign len  = LEN_FW'(rd_data[LEN_W-1:0]);

endmodule

// ----- hdl/pcbp_packer.sv -----
// Bit packer: accumulator, padding and merge of code bits, and the result
// emitter that sends up to four bytes of one item. Depends on pcbp_pkg.
module pcbp_packer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [2:0]                  pad_length,
  input  pcbp_pkg::stage_t            stage,
  input  logic [pcbp_pkg::CODE_W-1:0] code,
  input  logic [pcbp_pkg::LEN_FW-1:0] len,
  output logic                        go,
  output logic                        res_valid,
  input  logic                        res_stall,
  output pcbp_pkg::res_t              res
);
  import pcbp_pkg::*;

  logic [7:0]  acc;
  logic [2:0]  count;
  logic        started;
  logic [31:0] ebuf;
  logic [2:0]  ecnt;
  logic [1:0]  estat;

  logic [2:0]  padn;
  logic [3:0]  off;
  logic [6:0]  tot;
  logic [5:0]  sh;
  logic [47:0] merged;
  logic [2:0]  nbytes;
  logic [7:0]  acc_next;
  logic        need_emit;
  logic        em_free;
  logic        load_em;
  logic [31:0] ebuf_next;
  logic [2:0]  ecnt_next;
  logic [1:0]  estat_next;

  always_comb begin
    padn   = started ? 3'd0 : pad_length;
    off    = 4'({1'b0, count}) + 4'({1'b0, padn});
    tot    = 7'(off) + 7'(len);
    sh     = 6'(7'd48 - tot);
    merged = {acc, 40'b0} | (48'(code) << sh);
    nbytes = tot[5:3];
    unique case (nbytes)
      3'd0:    acc_next = merged[47:40];
      3'd1:    acc_next = merged[39:32];
      3'd2:    acc_next = merged[31:24];
      3'd3:    acc_next = merged[23:16];
      default: acc_next = merged[15:8];
    endcase
  end

  always_comb begin
    priority if (stage.finish) begin
      need_emit  = (count != 3'd0);
      ebuf_next  = {acc, 24'b0};
      ecnt_next  = 3'd1;
      estat_next = ST_FLUSH;
    end else if (!stage.known) begin
      need_emit  = 1'b1;
      ebuf_next  = 32'b0;
      ecnt_next  = 3'd1;
      estat_next = ST_UNKNOWN;
    end else begin
      need_emit  = (nbytes != 3'd0);
      ebuf_next  = merged[47:16];
      ecnt_next  = nbytes;
      estat_next = ST_BYTE;
    end
  end

  assign em_free = (ecnt == 3'd0) || ((ecnt == 3'd1) && !res_stall);
  assign go      = stage.valid && (!need_emit || em_free);
  assign load_em = go && need_emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc     <= 8'd0;
      count   <= 3'd0;
      started <= 1'b0;
      ecnt    <= 3'd0;
    end else begin
      if (go) begin
        if (stage.finish) begin
          acc     <= 8'd0;
          count   <= 3'd0;
          started <= 1'b0;
        end else if (stage.known) begin
          acc     <= acc_next;
          count   <= tot[2:0];
          started <= 1'b1;
        end
      end
      if (load_em) begin
        ecnt <= ecnt_next;
      end else if ((ecnt != 3'd0) && !res_stall) begin
        ecnt <= ecnt - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_em) begin
      ebuf  <= ebuf_next;
      estat <= estat_next;
    end else if ((ecnt != 3'd0) && !res_stall) begin
      ebuf <= {ebuf[23:0], 8'b0};
    end
  end

  assign res_valid    = (ecnt != 3'd0);
  assign res.out_byte = ebuf[31:24];
  assign res.status   = estat;
  assign res.last     = (ecnt == 3'd1);

endmodule

// ----- hdl/prefix_code_bit_packer_top.sv -----
// Top level of the prefix code bit packer: pad_length register, table
// lookup stage and bit packer. Depends on pcbp_pkg, pcbp_lookup, pcbp_packer.
//
//   channel | handshake            | payload
//   req     | req_valid / req_stall | pcbp_pkg::req_t
//   res     | res_valid / res_stall | pcbp_pkg::res_t
//   cfg     | cfg_valid / cfg_ready | pad_length, 3 bits
//
// An encode item reads the table RAM in its accept cycle, merges into the
// accumulator from the lookup stage register and then leaves its bytes one
// per cycle while res_stall is low. A new item is taken every cycle while
// the emitter keeps up with the result port.
// Reset is synchronous; the length valid bits clear at once, no clearing pass.
// res_stall holds the emitter and backs up into req_stall at the merge stage.
module prefix_code_bit_packer_top #(
  parameter int MAX_CODE_LEN = 32,
  parameter int SYMBOLS      = 256
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  pcbp_pkg::req_t  req,
  output logic            res_valid,
  input  logic            res_stall,
  output pcbp_pkg::res_t  res,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [2:0]      cfg_data
);
  import pcbp_pkg::*;

  logic              accept;
  logic              go;
  stage_t            stage;
  logic [CODE_W-1:0] code;
  logic [LEN_FW-1:0] len;
  logic [2:0]        pad_length;

  assign cfg_ready = 1'b1;
  assign req_stall = stage.valid && !go;
  assign accept    = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pad_length <= 3'd0;
    end else if (cfg_valid && cfg_ready) begin
      pad_length <= cfg_data;
    end
  end

  pcbp_lookup #(
    .MAX_CODE_LEN(MAX_CODE_LEN),
    .SYMBOLS     (SYMBOLS)
  ) u_lookup (
    .clk   (clk),
    .rst   (rst),
    .accept(accept),
    .req   (req),
    .go    (go),
    .stage (stage),
    .code  (code),
    .len   (len)
  );

  pcbp_packer u_packer (
    .clk       (clk),
    .rst       (rst),
    .pad_length(pad_length),
    .stage     (stage),
    .code      (code),
    .len       (len),
    .go        (go),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

// ----- hdl/pcbp_checker.sv -----
// Port-level checker for the prefix code bit packer, bound to the top level.
// Depends on pcbp_pkg and prefix_code_bit_packer_top.
module pcbp_checker (
  input logic            clk,
  input logic            rst,
  input logic            res_valid,
  input logic            res_stall,
  input pcbp_pkg::res_t  res
);
  import pcbp_pkg::*;

  a_reset_idle: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid)
    else $error("stalled result item dropped");

  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> $stable(res))
    else $error("stalled result item changed");

  a_unknown: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.status == ST_UNKNOWN) |-> res.last && (res.out_byte == 8'd0))
    else $error("unknown symbol result not single zero item");

  a_flush: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.status == ST_FLUSH) |-> res.last)
    else $error("flushed byte not last item");

endmodule

bind prefix_code_bit_packer_top pcbp_checker u_chk (.*);

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for prefix_code_bit_packer_top: directed and random items,
// a bit-exact packing predictor and per-field result checks.
// Depends on pcbp_pkg and the packer RTL.
module tb_top;
  import pcbp_pkg::*;

  localparam logic [1:0] REQ_UNUSED  = 2'd3;
  localparam logic [5:0] LEN_CAP     = 6'd32;
  localparam int         HOLD_CYCLES = 200;
  localparam int         DRAIN       = 12;
  localparam int         CYCLE_LIMIT = 300000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       req_valid = 1'b0;
  logic       req_stall;
  req_t       req = '0;
  logic       res_valid;
  logic       res_stall = 1'b0;
  res_t       res;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_data = 3'd0;

  req_t pending_reqs[$];
  res_t expected_bytes[$];
  res_t want;

  logic [31:0] code_copy [256];
  logic [5:0]  len_copy [256];
  logic [7:0]  acc = 8'h00;
  int unsigned acc_bits = 0;
  logic        started = 1'b0;
  logic [2:0]  pad_setting = 3'd0;

  logic [7:0]  sym_pool [16];
  int unsigned tx_gap_max = 7;
  int unsigned rx_wait_max = 7;
  int unsigned tx_wait;
  int unsigned rx_wait;
  logic        hold_kick = 1'b0;
  logic        rx_hold = 1'b0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  prefix_code_bit_packer_top DUT (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic res_t mk_res(logic [7:0] b, logic [1:0] s, logic l);
    res_t r;
    r.out_byte = b;
    r.status = s;
    r.last = l;
    return r;
  endfunction

  function automatic req_t mk_req(logic [1:0] t, logic [7:0] s, logic [31:0] c, logic [5:0] l);
    req_t it;
    it.req_type = t;
    it.symbol = s;
    it.code_word = c;
    it.code_length = l;
    return it;
  endfunction

  // Model an item: copy a load, queue the bytes an encode completes, flush on finish.
  function automatic void pack_item(req_t it);
    res_t made[$];
    res_t r;
    int unsigned len, npad, nbits, i;
    logic b;
    case (it.req_type)
      REQ_LOAD: begin
        code_copy[it.symbol] = it.code_word;
        len_copy[it.symbol] = (it.code_length > LEN_CAP) ? LEN_CAP : it.code_length;
      end
      REQ_ENCODE: begin
        len = 32'(len_copy[it.symbol]);
        if (len == 0) begin
          made.push_back(mk_res(8'h00, ST_UNKNOWN, 1'b1));
        end else begin
          npad = started ? 0 : 32'(pad_setting);
          started = 1'b1;
          nbits = npad + len;
          for (i = 0; i < nbits; i++) begin
            b = (i < npad) ? 1'b0 : code_copy[it.symbol][len - 1 - (i - npad)];
            acc = {acc[6:0], b};
            acc_bits++;
            if (acc_bits == 8) begin
              made.push_back(mk_res(acc, ST_BYTE, 1'b0));
              acc = 8'h00;
              acc_bits = 0;
            end
          end
          if (made.size() > 0) begin
            r = made.pop_back();
            r.last = 1'b1;
            made.push_back(r);
          end
        end
      end
      REQ_FINISH: begin
        if (acc_bits > 0) made.push_back(mk_res(acc << (8 - acc_bits), ST_FLUSH, 1'b1));
        acc = 8'h00;
        acc_bits = 0;
        started = 1'b0;
      end
      default: ;
    endcase
    foreach (made[k]) expected_bytes.push_back(made[k]);
  endfunction

  function automatic logic [5:0] gen_length();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) return 6'd0;
    if (pick < 10) return 6'($urandom_range(33, 63));
    if (pick < 75) return 6'($urandom_range(1, 12));
    return 6'($urandom_range(13, 32));
  endfunction

  function automatic req_t gen_item();
    req_t it;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < 80) it.symbol = sym_pool[$urandom_range(0, 15)];
    else it.symbol = 8'($urandom_range(0, 255));
    it.code_word = $urandom();
    it.code_length = 6'($urandom_range(0, 63));
    if (pick < 15) begin
      it.req_type = REQ_LOAD;
      it.code_length = gen_length();
    end else if (pick < 88) begin
      it.req_type = REQ_ENCODE;
    end else if (pick < 97) begin
      it.req_type = REQ_FINISH;
    end else begin
      it.req_type = REQ_UNUSED;
    end
    return it;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic write_pad(logic [2:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    pad_setting = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (pending_reqs.size() != 0 || req_valid || expected_bytes.size() != 0);
    repeat (DRAIN) @(negedge clk);
  endtask

  // Driver: hold a stalled item, otherwise wait out the drawn gap and offer the next one.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      tx_wait = 0;
    end else begin
      if (req_valid && !req_stall) pack_item(req);
      if (req_valid && req_stall) begin
      end else if (tx_wait > 0) begin
        tx_wait--;
        req_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        req <= pending_reqs.pop_front();
        req_valid <= 1'b1;
        tx_wait = $urandom_range(0, tx_gap_max);
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each accepted result against the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
      rx_wait = 0;
    end else begin
      if (res_valid && !res_stall) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected result byte %h status %0d last %0d",
                                    res.out_byte, res.status, res.last));
        end else begin
          want = expected_bytes.pop_front();
          if (res.out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte %h, want %h", res.out_byte, want.out_byte));
          if (res.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", res.status, want.status));
          if (res.last !== want.last)
            report_mismatch($sformatf("last %0d, want %0d", res.last, want.last));
        end
        rx_wait = $urandom_range(0, rx_wait_max);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      res_stall <= rx_hold || (rx_wait > 0);
    end
  end

  always @(posedge hold_kick) begin
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int ph;
    foreach (sym_pool[k]) sym_pool[k] = 8'($urandom_range(0, 255));
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    write_pad(3'd7);
    pending_reqs.push_back(mk_req(REQ_ENCODE, 8'h00, 32'h0, 6'd0));
    pending_reqs.push_back(mk_req(REQ_LOAD, 8'h00, 32'h0000_0001, 6'd1));
    pending_reqs.push_back(mk_req(REQ_LOAD, 8'hFF, 32'hFFFF_FFFF, 6'd32));
    pending_reqs.push_back(mk_req(REQ_LOAD, 8'h55, 32'hA5A5_A5A5, 6'd63));
    pending_reqs.push_back(mk_req(REQ_LOAD, 8'hAA, 32'h1234_5678, 6'd0));
    pending_reqs.push_back(mk_req(REQ_LOAD, 8'h80, 32'hDEAD_BEC3, 6'd8));
    pending_reqs.push_back(mk_req(REQ_LOAD, 8'h7F, 32'h0000_0155, 6'd9));
    pending_reqs.push_back(mk_req(REQ_ENCODE, 8'h00, 32'h0, 6'd0));
    pending_reqs.push_back(mk_req(REQ_ENCODE, 8'hFF, 32'h0, 6'd0));
    pending_reqs.push_back(mk_req(REQ_ENCODE, 8'h55, 32'h0, 6'd0));
    pending_reqs.push_back(mk_req(REQ_ENCODE, 8'hAA, 32'h0, 6'd0));
    pending_reqs.push_back(mk_req(REQ_FINISH, 8'h00, 32'h0, 6'd0));
    pending_reqs.push_back(mk_req(REQ_FINISH, 8'h00, 32'h0, 6'd0));
    pending_reqs.push_back(mk_req(REQ_ENCODE, 8'h7F, 32'h0, 6'd0));
    pending_reqs.push_back(mk_req(REQ_ENCODE, 8'h00, 32'h0, 6'd0));
    pending_reqs.push_back(mk_req(REQ_FINISH, 8'h00, 32'h0, 6'd0));
    pending_reqs.push_back(mk_req(REQ_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'd63));
    pending_reqs.push_back(mk_req(REQ_ENCODE, 8'h80, 32'h0, 6'd0));
    pending_reqs.push_back(mk_req(REQ_ENCODE, 8'hFF, 32'h0, 6'd0));
    pending_reqs.push_back(mk_req(REQ_FINISH, 8'h00, 32'h0, 6'd0));
    wait_idle();

    write_pad(3'd0);
    pending_reqs.push_back(mk_req(REQ_ENCODE, 8'h80, 32'h0, 6'd0));
    pending_reqs.push_back(mk_req(REQ_FINISH, 8'h00, 32'h0, 6'd0));
    pending_reqs.push_back(mk_req(REQ_ENCODE, 8'h00, 32'h0, 6'd0));
    pending_reqs.push_back(mk_req(REQ_ENCODE, 8'hAA, 32'h0, 6'd0));
    pending_reqs.push_back(mk_req(REQ_FINISH, 8'h00, 32'h0, 6'd0));
    wait_idle();

    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_pad(3'd0);
        1: write_pad(3'd7);
        default: write_pad(3'($urandom_range(0, 7)));
      endcase
      tx_gap_max = (ph == 2 || ph == 3) ? 0 : 7;
      rx_wait_max = (ph == 2) ? 0 : 7;
      if (ph == 0)
        foreach (sym_pool[k])
          pending_reqs.push_back(mk_req(REQ_LOAD, sym_pool[k], $urandom(),
                                        6'($urandom_range(1, 20))));
      repeat (54) pending_reqs.push_back(gen_item());
      if (ph == 3) hold_kick = 1'b1;
      wait_idle();
      hold_kick = 1'b0;
    end

    if (expected_bytes.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_bytes.size()));
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
